[src/lsbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbd_pkg
// Shared types and constants for the lsb stego bitmap deframer.
// ----------------------------------------------------------------------------
package lsbd_pkg;

  // register defaults and limits
  localparam logic [15:0] MagicWordReset   = 16'd10787;
  localparam logic [7:0]  HeaderBytesReset = 8'd54;
  localparam logic [31:0] MaxExtLen        = 32'd16;

  // configuration register indexes
  localparam logic CfgMagicWord   = 1'b0;
  localparam logic CfgHeaderBytes = 1'b1;

  // queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // result kinds
  typedef enum logic [2:0] {
    KIND_EXT_BYTE  = 3'd0,
    KIND_DATA_BYTE = 3'd1,
    KIND_EXT_LEN   = 3'd2,
    KIND_DATA_LEN  = 3'd3,
    KIND_BAD_MAGIC = 3'd4,
    KIND_EXT_LONG  = 3'd5
  } kind_e;

  // back end parse phase
  typedef enum logic [5:0] {
    PH_MAGIC   = 6'b000001,
    PH_EXTLEN  = 6'b000010,
    PH_EXT     = 6'b000100,
    PH_DATALEN = 6'b001000,
    PH_DATA    = 6'b010000,
    PH_IDLE    = 6'b100000
  } phase_e;

  // one classified image byte
  typedef struct packed {
    logic restart;   // frame start seen on this byte
    logic payload;   // byte carries a hidden bit
    logic data_bit;  // bit zero of the byte
  } entry_t;

endpackage

[src/lsbd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbd_in_if / lsbd_out_if
// Valid/ready channels for image bytes and recovered results.
// ----------------------------------------------------------------------------
interface lsbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       frame_start;

  modport source (output valid, output image_byte, output frame_start, input ready);
  modport sink   (input valid, input image_byte, input frame_start, output ready);
endinterface

interface lsbd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_value;
  logic [2:0]  out_kind;
  logic        out_last;

  modport source (output valid, output out_value, output out_kind, output out_last,
                  input ready);
  modport sink   (input valid, input out_value, input out_kind, input out_last,
                  output ready);
endinterface

[src/lsbd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbd_front
// Accepts image bytes, skips the bitmap header and classifies each byte.
// ----------------------------------------------------------------------------
module lsbd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         header_bytes_i,
  input  logic               in_valid_i,
  input  logic [7:0]         image_byte_i,
  input  logic               frame_start_i,
  output logic               in_ready_o,
  input  logic               q_full_i,
  output logic               push_o,
  output lsbd_pkg::entry_t   entry_o
);
  import lsbd_pkg::*;

  logic       hdr_active_q, hdr_active_d;
  logic [7:0] hdr_count_q, hdr_count_d;
  logic       accept;
  logic       act;
  logic [7:0] cnt;
  logic       skip;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // header skip after a frame start (or reset)
  assign act  = frame_start_i ? 1'b1 : hdr_active_q;
  assign cnt  = frame_start_i ? 8'd0 : hdr_count_q;
  assign skip = act && (cnt < header_bytes_i);

  always_comb begin
    hdr_active_d = hdr_active_q;
    hdr_count_d  = hdr_count_q;
    if (accept) begin
      hdr_active_d = skip;
      hdr_count_d  = skip ? cnt + 8'd1 : cnt;
    end
  end

  // only restarts and payload bytes go to the back end
  assign push_o           = accept && (frame_start_i || !skip);
  assign entry_o.restart  = frame_start_i;
  assign entry_o.payload  = !skip;
  assign entry_o.data_bit = image_byte_i[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_active_q <= 1'b1;
      hdr_count_q  <= 8'd0;
    end else begin
      hdr_active_q <= hdr_active_d;
      hdr_count_q  <= hdr_count_d;
    end
  end

endmodule

[src/lsbd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbd_fifo
// Short queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module lsbd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lsbd_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output lsbd_pkg::entry_t entry_o
);
  import lsbd_pkg::*;

  entry_t             mem_q [FifoDepth];
  logic [FifoAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FifoAw:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == (FifoAw + 1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (FifoAw + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (FifoAw + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[src/lsbd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbd_back
// Gathers hidden bits, parses the frame and holds results in an output register.
// ----------------------------------------------------------------------------
module lsbd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      magic_word_i,
  input  logic             q_empty_i,
  input  lsbd_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [31:0]      out_value_o,
  output logic [2:0]       out_kind_o,
  output logic             out_last_o
);
  import lsbd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  bit_count_q, bit_count_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  magic_low_q, magic_low_d;
  logic        magic_second_q, magic_second_d;
  logic [31:0] remaining_q, remaining_d;

  logic        valid_q, valid_d;
  logic [31:0] value_q, value_d;
  kind_e       kind_q, kind_d;
  logic        last_q, last_d;

  logic        emit;
  logic [31:0] word;
  logic        done;
  logic        take;

  // take the next byte when the output register is free or draining
  assign pop_o = !q_empty_i && (!valid_q || res_ready_i);

  always_comb begin
    phase_d        = phase_q;
    bit_count_d    = bit_count_q;
    shift_d        = shift_q;
    magic_low_d    = magic_low_q;
    magic_second_d = magic_second_q;
    remaining_d    = remaining_q;
    emit           = 1'b0;
    value_d        = value_q;
    kind_d         = kind_q;
    last_d         = last_q;
    word           = '0;
    done           = 1'b0;
    take           = 1'b0;

    if (pop_o) begin
      // frame start drops the current frame
      if (entry_i.restart) begin
        phase_d        = PH_MAGIC;
        bit_count_d    = '0;
        shift_d        = '0;
        magic_low_d    = '0;
        magic_second_d = 1'b0;
        remaining_d    = '0;
      end

      // bit gathering, lsb first
      take = entry_i.payload && (phase_d != PH_IDLE);
      word = shift_d | (32'(entry_i.data_bit) << bit_count_d);
      if (phase_d == PH_EXTLEN || phase_d == PH_DATALEN) begin
        done = (bit_count_d == 5'd31);
      end else begin
        done = (bit_count_d >= 5'd7);
      end
      if (take) begin
        if (done) begin
          shift_d     = '0;
          bit_count_d = '0;
        end else begin
          shift_d     = word;
          bit_count_d = bit_count_d + 5'd1;
        end
      end

      // frame parse on each completed value
      if (take && done) begin
        case (phase_d)
          PH_MAGIC: begin
            if (!magic_second_d) begin
              magic_low_d    = word[7:0];
              magic_second_d = 1'b1;
            end else begin
              magic_second_d = 1'b0;
              if ({word[7:0], magic_low_d} != magic_word_i) begin
                phase_d = PH_IDLE;
                emit    = 1'b1;
                value_d = '0;
                kind_d  = KIND_BAD_MAGIC;
                last_d  = 1'b0;
              end else begin
                phase_d = PH_EXTLEN;
              end
            end
          end
          PH_EXTLEN: begin
            emit   = 1'b1;
            last_d = 1'b0;
            if (word > MaxExtLen) begin
              phase_d = PH_IDLE;
              value_d = '0;
              kind_d  = KIND_EXT_LONG;
            end else begin
              remaining_d = word;
              phase_d     = (word == '0) ? PH_DATALEN : PH_EXT;
              value_d     = word;
              kind_d      = KIND_EXT_LEN;
            end
          end
          PH_EXT: begin
            remaining_d = remaining_d - 32'd1;
            if (remaining_d == '0) begin
              phase_d = PH_DATALEN;
            end
            emit    = 1'b1;
            value_d = {24'd0, word[7:0]};
            kind_d  = KIND_EXT_BYTE;
            last_d  = 1'b0;
          end
          PH_DATALEN: begin
            remaining_d = word;
            phase_d     = (word == '0) ? PH_IDLE : PH_DATA;
            emit        = 1'b1;
            value_d     = word;
            kind_d      = KIND_DATA_LEN;
            last_d      = (word == '0);
          end
          PH_DATA: begin
            remaining_d = remaining_d - 32'd1;
            emit        = 1'b1;
            value_d     = {24'd0, word[7:0]};
            kind_d      = KIND_DATA_BYTE;
            last_d      = (remaining_d == '0);
            if (remaining_d == '0) begin
              phase_d = PH_IDLE;
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end

    // output register occupancy
    if (emit) begin
      valid_d = 1'b1;
    end else if (res_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  assign res_valid_o = valid_q;
  assign out_value_o = value_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    kind_q  <= kind_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_MAGIC;
      bit_count_q    <= '0;
      shift_q        <= '0;
      magic_low_q    <= '0;
      magic_second_q <= 1'b0;
      remaining_q    <= '0;
      valid_q        <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      bit_count_q    <= bit_count_d;
      shift_q        <= shift_d;
      magic_low_q    <= magic_low_d;
      magic_second_q <= magic_second_d;
      remaining_q    <= remaining_d;
      valid_q        <= valid_d;
    end
  end

endmodule

[src/lsb_stego_bmp_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_stego_bmp_deframer
// Recovers a hidden frame from bit zero of a bitmap byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   src_i carries one image byte per transaction; frame_start marks the first
//   byte of an image and restarts parsing. res_o carries one recovered value
//   per transaction: magic and extension length errors, the extension length,
//   extension bytes, the data length and data bytes, the final one flagged.
//   Configuration (magic word, header length) is written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i while no transaction is in flight.
// Timing:
//   one image byte per cycle sustained while res_o is not stalled. The byte
//   that completes a result is classified and written into the queue when
//   it is accepted; the back end then pops it and parses the result into the
//   output register.
// Reset:
//   parsing starts as if a frame had begun; registers take their defaults.
// Stalls:
//   while res_o is stalled the back end holds; a two-entry queue keeps
//   accepting bytes until it fills, then src_i.ready drops.
// ----------------------------------------------------------------------------
module lsb_stego_bmp_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsbd_in_if.sink     src_i,
  lsbd_out_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import lsbd_pkg::*;

  logic [15:0] magic_word_q;
  logic [7:0]  header_bytes_q;
  logic        q_full, q_empty, push, pop;
  entry_t      push_entry, pop_entry;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q   <= MagicWordReset;
      header_bytes_q <= HeaderBytesReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMagicWord:   magic_word_q   <= cfg_wdata_i;
        CfgHeaderBytes: header_bytes_q <= cfg_wdata_i[7:0];
        default:        magic_word_q   <= magic_word_q;
      endcase
    end
  end

  // front end: header skip and classification
  lsbd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .header_bytes_i (header_bytes_q),
    .in_valid_i     (src_i.valid),
    .image_byte_i   (src_i.image_byte),
    .frame_start_i  (src_i.frame_start),
    .in_ready_o     (src_i.ready),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  // queue between the two halves
  lsbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .entry_o (pop_entry)
  );

  // back end: bit gathering and frame parse
  lsbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .magic_word_i (magic_word_q),
    .q_empty_i    (q_empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .out_value_o  (res_o.out_value),
    .out_kind_o   (res_o.out_kind),
    .out_last_o   (res_o.out_last)
  );

endmodule
